### src/tsfla_pkg.sv
// ---------------------------------------------------------------------------
// tsfla_pkg
// Shared sizes, operation codes and types of the thread slot allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsfla_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int STAMP_W = 48;
    localparam int PROD_W  = CNT_W + STAMP_W;
    localparam int INTEG_W = 64;

    localparam logic [1:0] FN_ALLOC     = 2'd0;
    localparam logic [1:0] FN_FREE      = 2'd1;
    localparam logic [1:0] FN_RESERVE   = 2'd2;
    localparam logic [1:0] FN_UNRESERVE = 2'd3;

    localparam logic [1:0] CTX_NORMAL    = 2'd0;
    localparam logic [1:0] CTX_RESERVED  = 2'd1;
    localparam logic [1:0] CTX_EXCLUSIVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERR   = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic calc;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

### src/tsfla_ctrl.sv
// ---------------------------------------------------------------------------
// tsfla_ctrl
// Request sequencer: capture, link table read, check/multiply, commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsfla_ctrl
    import tsfla_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        IDLE,
        READ,
        CALC,
        COMMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd.capture = s_valid && s_ready_reg;
        cmd.read    = (state_reg == READ);
        cmd.calc    = (state_reg == CALC);
        cmd.commit  = (state_reg == COMMIT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (cmd.capture) begin
                        state_reg   <= READ;
                        s_ready_reg <= 1'b0;
                    end else begin
                        s_ready_reg <= 1'b1;
                    end
                end
                READ: begin
                    state_reg <= CALC;
                end
                CALC: begin
                    state_reg <= COMMIT;
                end
                COMMIT: begin
                    if (cmd.commit) begin
                        state_reg   <= IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
            endcase
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### src/tsfla_dp.sv
// ---------------------------------------------------------------------------
// tsfla_dp
// Link table, class counters, occupancy statistics and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsfla_dp
    import tsfla_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dp_cmd_t             cmd,
    input  wire logic [1:0]          s_func,
    input  wire logic [1:0]          s_context_req,
    input  wire logic [7:0]          s_slot_in,
    input  wire logic [STAMP_W-1:0]  s_cycle_stamp,
    output logic [1:0]               m_status,
    output logic [7:0]               m_slot_out,
    output logic [8:0]               m_free_normal,
    output logic [8:0]               m_free_reserved,
    output logic                     m_free_exclusive,
    output logic [8:0]               m_free_of_context,
    output logic                     m_table_empty,
    output logic [8:0]               m_current_alloc,
    output logic [8:0]               m_max_alloc,
    output logic [INTEG_W-1:0]       m_total_alloc
);

    // request capture
    logic [1:0]          func_reg;
    logic [1:0]          ctx_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [STAMP_W-1:0]  stamp_reg;

    // link table; entries never written read as index + 1
    logic [LINK_W-1:0]   link_mem [SLOTS];
    logic [SLOTS-1:0]    link_vld_reg;
    logic [LINK_W-1:0]   rd_data_reg;
    logic                rd_vld_reg;
    logic [SLOT_W-1:0]   rd_addr_reg;

    // allocator state
    logic [LINK_W-1:0]   head_reg;
    logic [CNT_W-1:0]    cnt_normal_reg;
    logic [CNT_W-1:0]    cnt_reserved_reg;
    logic                cnt_excl_reg;
    logic [STAMP_W-1:0]  last_stamp_reg;
    logic [CNT_W-1:0]    occ_now_reg;
    logic [CNT_W-1:0]    occ_peak_reg;
    logic [INTEG_W-1:0]  integ_reg;

    // check stage
    status_t             status_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [PROD_W-1:0]   prod_reg;

    // result registers
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [CNT_W-1:0]    out_normal_reg;
    logic [CNT_W-1:0]    out_reserved_reg;
    logic                out_excl_reg;
    logic [CNT_W-1:0]    out_ctx_reg;
    logic                out_empty_reg;
    logic [CNT_W-1:0]    out_occ_reg;
    logic [CNT_W-1:0]    out_peak_reg;
    logic [INTEG_W-1:0]  out_integ_reg;

    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    cls_cnt;
    logic                cls_valid;
    logic                slot_ok;
    status_t             status_calc;
    logic [CNT_W-1:0]    occ_calc;
    logic [STAMP_W-1:0]  elapsed;
    logic [LINK_W-1:0]   link_rd;
    logic                ok;

    logic [LINK_W-1:0]   head_next;
    logic [CNT_W-1:0]    cnt_normal_next;
    logic [CNT_W-1:0]    cnt_reserved_next;
    logic                cnt_excl_next;
    logic [STAMP_W-1:0]  last_stamp_next;
    logic [CNT_W-1:0]    occ_now_next;
    logic [CNT_W-1:0]    occ_peak_next;
    logic [INTEG_W-1:0]  integ_next;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    ctx_cnt_next;
    logic [SLOT_W-1:0]   slot_out_next;

    // ---- check stage logic ----
    always_comb begin
        sum = SUM_W'(cnt_normal_reg) + SUM_W'(cnt_reserved_reg) + SUM_W'(cnt_excl_reg);
        cls_valid = 1'b1;
        unique case (ctx_reg)
            CTX_NORMAL:    cls_cnt = cnt_normal_reg;
            CTX_RESERVED:  cls_cnt = cnt_reserved_reg;
            CTX_EXCLUSIVE: cls_cnt = CNT_W'(cnt_excl_reg);
            default: begin
                cls_cnt   = '0;
                cls_valid = 1'b0;
            end
        endcase
        slot_ok = (LINK_W'(slot_reg) < LINK_W'(SLOTS));
        unique case (func_reg)
            FN_ALLOC: begin
                if (!cls_valid) begin
                    status_calc = ST_ERR;
                end else if (cls_cnt == '0) begin
                    status_calc = ST_EMPTY;
                end else if (head_reg >= LINK_W'(SLOTS)) begin
                    status_calc = ST_ERR;
                end else begin
                    status_calc = ST_OK;
                end
            end
            FN_FREE: begin
                if (!cls_valid || !slot_ok || sum >= SUM_W'(SLOTS)
                        || (ctx_reg == CTX_EXCLUSIVE && cnt_excl_reg)) begin
                    status_calc = ST_ERR;
                end else begin
                    status_calc = ST_OK;
                end
            end
            FN_RESERVE:   status_calc = (cnt_normal_reg == '0) ? ST_ERR : ST_OK;
            FN_UNRESERVE: status_calc = (cnt_reserved_reg == '0) ? ST_ERR : ST_OK;
            default:      status_calc = ST_ERR;
        endcase
        occ_calc = (sum <= SUM_W'(SLOTS)) ? CNT_W'(SUM_W'(SLOTS) - sum) : '0;
        elapsed  = stamp_reg - last_stamp_reg;
    end

    // ---- commit logic ----
    always_comb begin
        link_rd           = rd_vld_reg ? rd_data_reg : LINK_W'(rd_addr_reg) + LINK_W'(1);
        ok                = (status_reg == ST_OK);
        head_next         = head_reg;
        cnt_normal_next   = cnt_normal_reg;
        cnt_reserved_next = cnt_reserved_reg;
        cnt_excl_next     = cnt_excl_reg;
        last_stamp_next   = last_stamp_reg;
        occ_now_next      = occ_now_reg;
        occ_peak_next     = occ_peak_reg;
        integ_next        = integ_reg;
        slot_out_next     = '0;
        if (ok) begin
            last_stamp_next = stamp_reg;
            occ_now_next    = occ_reg;
            occ_peak_next   = (occ_reg > occ_peak_reg) ? occ_reg : occ_peak_reg;
            integ_next      = integ_reg + INTEG_W'(prod_reg);
            unique case (func_reg)
                FN_ALLOC: begin
                    head_next     = link_rd;
                    slot_out_next = head_reg[SLOT_W-1:0];
                    if (ctx_reg == CTX_NORMAL) begin
                        cnt_normal_next = cnt_normal_reg - CNT_W'(1);
                    end else if (ctx_reg == CTX_RESERVED) begin
                        cnt_reserved_next = cnt_reserved_reg - CNT_W'(1);
                    end else begin
                        cnt_excl_next = 1'b0;
                    end
                end
                FN_FREE: begin
                    head_next = LINK_W'(slot_reg);
                    if (ctx_reg == CTX_NORMAL) begin
                        cnt_normal_next = cnt_normal_reg + CNT_W'(1);
                    end else if (ctx_reg == CTX_RESERVED) begin
                        cnt_reserved_next = cnt_reserved_reg + CNT_W'(1);
                    end else begin
                        cnt_excl_next = 1'b1;
                    end
                end
                FN_RESERVE: begin
                    cnt_normal_next   = cnt_normal_reg - CNT_W'(1);
                    cnt_reserved_next = cnt_reserved_reg + CNT_W'(1);
                end
                FN_UNRESERVE: begin
                    cnt_normal_next   = cnt_normal_reg + CNT_W'(1);
                    cnt_reserved_next = cnt_reserved_reg - CNT_W'(1);
                end
                default: begin
                    head_next = head_reg;
                end
            endcase
        end
        sum_next = SUM_W'(cnt_normal_next) + SUM_W'(cnt_reserved_next)
                 + SUM_W'(cnt_excl_next);
        unique case (ctx_reg)
            CTX_NORMAL:    ctx_cnt_next = cnt_normal_next;
            CTX_RESERVED:  ctx_cnt_next = cnt_reserved_next;
            CTX_EXCLUSIVE: ctx_cnt_next = CNT_W'(cnt_excl_next);
            default:       ctx_cnt_next = '0;
        endcase
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_func;
            ctx_reg   <= s_context_req;
            slot_reg  <= s_slot_in[SLOT_W-1:0];
            stamp_reg <= s_cycle_stamp;
        end
        if (cmd.read) begin
            rd_addr_reg <= head_reg[SLOT_W-1:0];
            rd_data_reg <= link_mem[head_reg[SLOT_W-1:0]];
            rd_vld_reg  <= link_vld_reg[head_reg[SLOT_W-1:0]];
        end
        if (cmd.calc) begin
            status_reg <= status_calc;
            occ_reg    <= occ_calc;
            prod_reg   <= PROD_W'(occ_calc) * PROD_W'(elapsed);
        end
        if (cmd.commit) begin
            out_status_reg   <= status_reg;
            out_slot_reg     <= slot_out_next;
            out_normal_reg   <= cnt_normal_next;
            out_reserved_reg <= cnt_reserved_next;
            out_excl_reg     <= cnt_excl_next;
            out_ctx_reg      <= ctx_cnt_next;
            out_empty_reg    <= (sum_next == SUM_W'(SLOTS));
            out_occ_reg      <= occ_now_next;
            out_peak_reg     <= occ_peak_next;
            out_integ_reg    <= integ_next;
        end
    end

    // ---- link table write port ----
    always_ff @(posedge aclk) begin
        if (cmd.commit && ok && func_reg == FN_FREE) begin
            link_mem[slot_reg] <= head_reg;
        end
    end

    // ---- allocator state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg     <= '0;
            head_reg         <= '0;
            cnt_normal_reg   <= CNT_W'(SLOTS - 1);
            cnt_reserved_reg <= '0;
            cnt_excl_reg     <= 1'b1;
            last_stamp_reg   <= '0;
            occ_now_reg      <= '0;
            occ_peak_reg     <= '0;
            integ_reg        <= '0;
        end else if (cmd.commit) begin
            if (ok && func_reg == FN_FREE) begin
                link_vld_reg[slot_reg] <= 1'b1;
            end
            head_reg         <= head_next;
            cnt_normal_reg   <= cnt_normal_next;
            cnt_reserved_reg <= cnt_reserved_next;
            cnt_excl_reg     <= cnt_excl_next;
            last_stamp_reg   <= last_stamp_next;
            occ_now_reg      <= occ_now_next;
            occ_peak_reg     <= occ_peak_next;
            integ_reg        <= integ_next;
        end
    end

    assign m_status          = out_status_reg;
    assign m_slot_out        = out_slot_reg;
    assign m_free_normal     = out_normal_reg;
    assign m_free_reserved   = out_reserved_reg;
    assign m_free_exclusive  = out_excl_reg;
    assign m_free_of_context = out_ctx_reg;
    assign m_table_empty     = out_empty_reg;
    assign m_current_alloc   = out_occ_reg;
    assign m_max_alloc       = out_peak_reg;
    assign m_total_alloc     = out_integ_reg;

endmodule

`default_nettype wire

### src/thread_slot_free_list_allocator.sv
// Thread slot allocator: each request (allocate, free, reserve, unreserve)
// runs to a valid result before the next one is taken; the next request is
// accepted on the cycle after the result is loaded. The four steps are
// capture, a registered read of the next-link table at the free list head,
// the class check together with the occupancy-times-elapsed multiply, and
// the commit of counters, statistics and the result register. A new request
// may be accepted while the previous result still waits on m_ready; a
// request stalls in its commit step only if that earlier result has not
// been taken yet. The link table has no clearing pass after reset:
// per-entry valid bits make untouched entries read as their reset link.
// ---------------------------------------------------------------------------
// thread_slot_free_list_allocator
// Free list slot allocator with normal, reserved and exclusive free counts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thread_slot_free_list_allocator
    import tsfla_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire logic [1:0]          s_context_req,
    input  wire logic [7:0]          s_slot_in,
    input  wire logic [STAMP_W-1:0]  s_cycle_stamp,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [7:0]               m_slot_out,
    output logic [8:0]               m_free_normal,
    output logic [8:0]               m_free_reserved,
    output logic                     m_free_exclusive,
    output logic [8:0]               m_free_of_context,
    output logic                     m_table_empty,
    output logic [8:0]               m_current_alloc,
    output logic [8:0]               m_max_alloc,
    output logic [INTEG_W-1:0]       m_total_alloc
);

    dp_cmd_t cmd;

    tsfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tsfla_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_func            (s_func),
        .s_context_req     (s_context_req),
        .s_slot_in         (s_slot_in),
        .s_cycle_stamp     (s_cycle_stamp),
        .m_status          (m_status),
        .m_slot_out        (m_slot_out),
        .m_free_normal     (m_free_normal),
        .m_free_reserved   (m_free_reserved),
        .m_free_exclusive  (m_free_exclusive),
        .m_free_of_context (m_free_of_context),
        .m_table_empty     (m_table_empty),
        .m_current_alloc   (m_current_alloc),
        .m_max_alloc       (m_max_alloc),
        .m_total_alloc     (m_total_alloc)
    );

endmodule

`default_nettype wire

### src/tsfla_checker.sv
// ---------------------------------------------------------------------------
// tsfla_checker
// Port-level checks of the slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsfla_checker
    import tsfla_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [1:0]          m_status,
    input wire logic [7:0]          m_slot_out,
    input wire logic [8:0]          m_free_normal,
    input wire logic [8:0]          m_free_reserved,
    input wire logic                m_free_exclusive,
    input wire logic                m_table_empty,
    input wire logic [8:0]          m_current_alloc,
    input wire logic [8:0]          m_max_alloc,
    input wire logic [INTEG_W-1:0]  m_total_alloc
);

    logic [SUM_W-1:0] free_sum;

    assign free_sum = SUM_W'(m_free_normal) + SUM_W'(m_free_reserved)
                    + SUM_W'(m_free_exclusive);

    // stalled request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_alloc) && $stable(m_status))
        else $error("result changed while stalled");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_max_alloc >= m_current_alloc)
        else $error("peak occupancy below current occupancy");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_table_empty == (free_sum == SUM_W'(SLOTS)))
        else $error("table_empty disagrees with free counts");

    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_slot_out == '0)
        else $error("slot granted on a failed request");

endmodule

bind thread_slot_free_list_allocator tsfla_checker u_tsfla_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_slot_out       (m_slot_out),
    .m_free_normal    (m_free_normal),
    .m_free_reserved  (m_free_reserved),
    .m_free_exclusive (m_free_exclusive),
    .m_table_empty    (m_table_empty),
    .m_current_alloc  (m_current_alloc),
    .m_max_alloc      (m_max_alloc),
    .m_total_alloc    (m_total_alloc)
);

`default_nettype wire
